// ===== hdl/htwd_pkg.sv =====
// Package for the Huffman tree-walk decoder: field widths, command codes, shared types.
// No dependencies; every other file of the block uses it by scoped names.
package htwd_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int ENTRY_W = 16;
    localparam int SYM_W   = 8;
    localparam int CNT_W   = 31;
    // Pointer plus signed increment; also wide enough for the biased sum in the wrap unit.
    localparam int SUM_W   = 18;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CODE  = 2'd2;

    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic [CNT_W-1:0]          t_count;

endpackage

// ===== hdl/htwd_wrap.sv =====
// Two-stage modulo unit: reduces a signed pointer sum into 0..TREE_DEPTH-1.
// Depends on htwd_pkg; uses reciprocal multiply with one correction step.
module htwd_wrap #(
    parameter int TREE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  htwd_pkg::t_sum                 i_value,
    output logic                           o_valid,
    output logic [$clog2(TREE_DEPTH)-1:0]  o_addr
);

    localparam int AW     = $clog2(TREE_DEPTH);
    localparam int XW     = htwd_pkg::SUM_W;
    localparam int BIAS   = ((2 ** (htwd_pkg::ENTRY_W - 1) + TREE_DEPTH - 1) / TREE_DEPTH)
                            * TREE_DEPTH;
    localparam int RECIP  = (2 ** XW + TREE_DEPTH - 1) / TREE_DEPTH;
    localparam int RW     = $clog2(RECIP + 1);

    logic                    r_v1;
    logic                    r_v2;
    logic [XW-1:0]           r_x;
    logic [AW-1:0]           r_addr;
    logic [XW-1:0]           n_x;
    logic signed [XW:0]      w_biased;
    logic [XW+RW-1:0]        w_prod;
    logic [RW-1:0]           w_quot;
    logic [RW+AW:0]          w_qd;
    logic signed [XW+1:0]    w_rem;
    logic signed [XW+1:0]    w_rem_fix;
    logic [AW-1:0]           n_addr;

    // Bias the sum so it is never negative; the bias is a multiple of the depth.
    assign w_biased = (XW + 1)'(i_value) + (XW + 1)'(BIAS);
    assign n_x      = w_biased[XW-1:0];

    // Quotient estimate is exact or one too large.
    assign w_prod = (XW + RW)'(r_x) * (XW + RW)'(RECIP);
    assign w_quot = w_prod[XW +: RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_addr <= n_addr;
    end

    // Second stage: quotient, remainder and one correction, all from the registered r_x.
    assign w_qd      = (RW + AW + 1)'(w_quot) * (RW + AW + 1)'(TREE_DEPTH);
    assign w_rem     = $signed({2'b00, r_x}) - $signed({1'b0, w_qd[XW:0]});
    assign w_rem_fix = (w_rem < 0) ? w_rem + (XW + 2)'(TREE_DEPTH) : w_rem;
    assign n_addr    = w_rem_fix[AW-1:0];

    assign o_valid = r_v2;
    assign o_addr  = r_addr;

endmodule

// ===== hdl/htwd_table.sv =====
// Tree table memory: one write or read per cycle, registered read data.
// Depends on htwd_pkg for the entry type.
module htwd_table #(
    parameter int TREE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic                           i_rd_en,
    input  logic [$clog2(TREE_DEPTH)-1:0]  i_addr,
    input  htwd_pkg::t_entry               i_wr_data,
    output htwd_pkg::t_entry               o_rd_data
);

    htwd_pkg::t_entry mem [TREE_DEPTH];
    htwd_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/huffman_tree_walk_decoder.sv =====
// Top level of the Huffman tree-walk decoder: command sequencer and pointer walk.
// Depends on htwd_pkg, htwd_table (tree memory) and htwd_wrap (pointer modulo unit).
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+----------------------------------
//  command   | in        | i_start, o_busy              | i_command, i_entry_index,
//            |           |                              | i_entry_value, i_code_word
//  config    | in        | i_cfg_wr_en                  | i_cfg_wr_data (symbol_count)
//  result    | out       | o_symbol_valid (one cycle)   | o_symbol, o_last_symbol
//
// A transaction is taken at a rising edge with i_start high and o_busy low.
// Start and ignored commands leave o_busy low; a load keeps o_busy high while the index
// goes through the modulo unit.
// A code word keeps o_busy high while it consumes bits and emits symbols; each bit is
// one table read, the two-stage modulo of pos+increment and one leaf-test read, and each
// decoded symbol adds one symbol read, all through the single table port.
// Synchronous active-low reset returns the walk to the root with nothing to decode;
// the table contents are not cleared. Results cannot be stalled: each strobe is one cycle.
module huffman_tree_walk_decoder #(
    parameter int TREE_DEPTH = 1024,
    parameter int WORD_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [htwd_pkg::CMD_W-1:0]         i_command,
    input  logic [htwd_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [htwd_pkg::ENTRY_W-1:0] i_entry_value,
    input  logic [WORD_BITS-1:0]               i_code_word,
    input  logic                               i_cfg_wr_en,
    input  logic [htwd_pkg::CNT_W-1:0]         i_cfg_wr_data,
    output logic                               o_symbol_valid,
    output logic [htwd_pkg::SYM_W-1:0]         o_symbol,
    output logic                               o_last_symbol
);

    localparam int AW = $clog2(TREE_DEPTH);
    localparam int BW = $clog2(WORD_BITS + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;   // wait for wrapped load index
    localparam logic [2:0] S_SUM  = 3'd2;   // increment on read data, send pos+inc to wrap
    localparam logic [2:0] S_WSUM = 3'd3;   // wait for wrapped pointer, read its entry
    localparam logic [2:0] S_LEAF = 3'd4;   // leaf test on the new pointer's entry
    localparam logic [2:0] S_SYM  = 3'd5;   // symbol entry on read data, emit

    logic [2:0]                   r_state, n_state;
    logic [AW-1:0]                r_pos, n_pos;
    logic [AW-1:0]                r_pos_new, n_pos_new;
    htwd_pkg::t_count             r_left, n_left;
    logic                         r_done, n_done;
    htwd_pkg::t_count             r_cfg_count;
    logic [WORD_BITS-1:0]         r_word, n_word;
    logic [BW-1:0]                r_bits_left, n_bits_left;
    htwd_pkg::t_entry             r_entry, n_entry;
    logic                         r_out_valid, n_out_valid;
    logic [htwd_pkg::SYM_W-1:0]   r_out_symbol, n_out_symbol;
    logic                         r_out_last, n_out_last;

    logic                         w_accept;
    logic [WORD_BITS-1:0]         w_word_shl;
    logic                         w_next_bit;
    logic                         w_more_bits;
    htwd_pkg::t_count             w_left_dec;
    logic                         w_last;

    logic                         tbl_we;
    logic                         tbl_rd;
    logic [AW-1:0]                tbl_addr;
    htwd_pkg::t_entry             tbl_rd_data;

    logic                         wrap_in_valid;
    htwd_pkg::t_sum               wrap_in_value;
    logic                         wrap_out_valid;
    logic [AW-1:0]                wrap_out_addr;

    // pos + bit, or pos + 1, modulo the depth
    function automatic logic [AW-1:0] step_addr(input logic [AW-1:0] p, input logic b);
        logic [AW:0] s;
        s = {1'b0, p} + (AW + 1)'(b);
        if (s == (AW + 1)'(TREE_DEPTH)) begin
            s = '0;
        end
        return s[AW-1:0];
    endfunction

    htwd_table #(
        .TREE_DEPTH (TREE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_rd_en   (tbl_rd),
        .i_addr    (tbl_addr),
        .i_wr_data (r_entry),
        .o_rd_data (tbl_rd_data)
    );

    htwd_wrap #(
        .TREE_DEPTH (TREE_DEPTH)
    ) u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (wrap_in_valid),
        .i_value (wrap_in_value),
        .o_valid (wrap_out_valid),
        .o_addr  (wrap_out_addr)
    );

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_word_shl  = r_word << 1;
    assign w_next_bit  = w_word_shl[WORD_BITS-1];
    assign w_more_bits = (r_bits_left != BW'(1));
    assign w_left_dec  = r_left - htwd_pkg::t_count'(1);
    assign w_last      = (w_left_dec == '0);

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_pos_new     = r_pos_new;
        n_left        = r_left;
        n_done        = r_done;
        n_word        = r_word;
        n_bits_left   = r_bits_left;
        n_entry       = r_entry;
        n_out_valid   = 1'b0;
        n_out_symbol  = r_out_symbol;
        n_out_last    = r_out_last;
        tbl_we        = 1'b0;
        tbl_rd        = 1'b0;
        tbl_addr      = r_pos;
        wrap_in_valid = 1'b0;
        wrap_in_value = $signed(htwd_pkg::SUM_W'(i_entry_index));

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        htwd_pkg::CMD_LOAD: begin
                            // wrap the index first, write when it comes back
                            wrap_in_valid = 1'b1;
                            n_entry       = i_entry_value;
                            n_state       = S_LOAD;
                        end
                        htwd_pkg::CMD_START: begin
                            n_pos  = '0;
                            n_left = r_cfg_count;
                            n_done = (r_cfg_count == '0);
                        end
                        htwd_pkg::CMD_CODE: begin
                            // drop the word once the stream is finished
                            if (!r_done) begin
                                n_word      = i_code_word;
                                n_bits_left = BW'(WORD_BITS);
                                tbl_rd      = 1'b1;
                                tbl_addr    = step_addr(r_pos, i_code_word[WORD_BITS-1]);
                                n_state     = S_SUM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (wrap_out_valid) begin
                    tbl_we   = 1'b1;
                    tbl_addr = wrap_out_addr;
                    n_state  = S_IDLE;
                end
            end
            S_SUM: begin
                wrap_in_valid = 1'b1;
                wrap_in_value = $signed(htwd_pkg::SUM_W'(r_pos))
                              + htwd_pkg::SUM_W'(tbl_rd_data);
                n_state       = S_WSUM;
            end
            S_WSUM: begin
                if (wrap_out_valid) begin
                    n_pos_new = wrap_out_addr;
                    tbl_rd    = 1'b1;
                    tbl_addr  = wrap_out_addr;
                    n_state   = S_LEAF;
                end
            end
            S_LEAF: begin
                if (tbl_rd_data == '0) begin
                    // leaf: fetch the symbol that follows the marker
                    tbl_rd   = 1'b1;
                    tbl_addr = step_addr(r_pos_new, 1'b1);
                    n_state  = S_SYM;
                end else begin
                    n_pos       = r_pos_new;
                    n_word      = w_word_shl;
                    n_bits_left = r_bits_left - BW'(1);
                    if (w_more_bits) begin
                        tbl_rd   = 1'b1;
                        tbl_addr = step_addr(r_pos_new, w_next_bit);
                        n_state  = S_SUM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SYM: begin
                n_out_valid  = 1'b1;
                n_out_symbol = tbl_rd_data[htwd_pkg::SYM_W-1:0];
                n_out_last   = w_last;
                n_left       = w_left_dec;
                n_done       = w_last;
                n_pos        = '0;
                n_word       = w_word_shl;
                n_bits_left  = r_bits_left - BW'(1);
                // back to the root; stop on the last symbol or the end of the word
                if (w_more_bits && !w_last) begin
                    tbl_rd   = 1'b1;
                    tbl_addr = step_addr('0, w_next_bit);
                    n_state  = S_SUM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_left      <= '0;
            r_done      <= 1'b1;
            r_cfg_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_left      <= n_left;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_cfg_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_new    <= n_pos_new;
        r_word       <= n_word;
        r_bits_left  <= n_bits_left;
        r_entry      <= n_entry;
        r_out_symbol <= n_out_symbol;
        r_out_last   <= n_out_last;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_symbol_valid = r_out_valid;
    assign o_symbol       = r_out_symbol;
    assign o_last_symbol  = r_out_last;

endmodule

// ===== hdl/htwd_checker.sv =====
// Port-level assertions for the Huffman tree-walk decoder, bound to the top level.
// Depends on htwd_pkg and huffman_tree_walk_decoder.
module htwd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_start,
    input logic                                o_busy,
    input logic [htwd_pkg::CMD_W-1:0]          i_command,
    input logic                                o_symbol_valid
);

    logic accept;
    assign accept = i_start && !o_busy;

    // symbol strobes are never back to back; in the design they come at least a bit-walk apart
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_symbol_valid |=> !o_symbol_valid)
        else $error("symbol strobe on two adjacent cycles");

    a_start_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == htwd_pkg::CMD_START) |=> (!o_busy && !o_symbol_valid))
        else $error("start command did not complete in one cycle");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == htwd_pkg::CMD_LOAD) |=> (o_busy && !o_symbol_valid))
        else $error("load command did not hold busy");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_busy && !o_symbol_valid))
        else $error("not idle after reset");

endmodule

bind huffman_tree_walk_decoder htwd_checker u_htwd_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for huffman_tree_walk_decoder: tree loads, stream starts, code words.
// Depends on htwd_pkg and the decoder RTL; predicts every decoded symbol with its own tree walk.
`timescale 1ns / 1ps

module testbench;

    // The package names three commands; the fourth encoding must be dropped by the block.
    localparam logic [htwd_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

    localparam int TABLE_SIZE   = 1024;
    localparam int ITEM_TARGET  = 480;
    localparam int STALL_LIMIT  = 2000;  // quiet cycles before the run is declared hung
    localparam int DRAIN_CYCLES = 100;   // longer than the slowest code word

    typedef struct packed {
        logic [htwd_pkg::SYM_W-1:0] sym;
        logic                       is_last;
    } t_symbol_exp;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_start = 1'b0;
    logic                                o_busy;
    logic [htwd_pkg::CMD_W-1:0]          i_command = CMD_NONE;
    logic [htwd_pkg::IDX_W-1:0]          i_entry_index = '0;
    logic signed [htwd_pkg::ENTRY_W-1:0] i_entry_value = '0;
    logic [15:0]                         i_code_word = '0;
    logic                                i_cfg_wr_en = 1'b0;
    logic [htwd_pkg::CNT_W-1:0]          i_cfg_wr_data = '0;
    logic                                o_symbol_valid;
    logic [htwd_pkg::SYM_W-1:0]          o_symbol;
    logic                                o_last_symbol;

    // Predictor state: tree table with a written flag per entry, walk pointer, count.
    logic [htwd_pkg::ENTRY_W-1:0] tree_mem [TABLE_SIZE];
    bit                           tree_written [TABLE_SIZE];
    logic [htwd_pkg::IDX_W-1:0]   walk_pos = '0;
    htwd_pkg::t_count             left_cnt = '0;
    bit                           walk_done = 1'b1;
    htwd_pkg::t_count             count_reg = '0;
    t_symbol_exp                  pending_symbols [$];
    t_symbol_exp                  want;

    bit gaps_on = 1'b0;
    int errors = 0;
    int items_sent = 0;
    int n_loads = 0;
    int n_starts = 0;
    int n_codes = 0;
    int symbols_checked = 0;
    int trees_built = 0;
    int fills = 0;
    int quiet_cycles = 0;

    huffman_tree_walk_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_command      (i_command),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_code_word    (i_code_word),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_symbol_valid (o_symbol_valid),
        .o_symbol       (o_symbol),
        .o_last_symbol  (o_last_symbol)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Walk one code word through the predicted table. With commit set, advance the walk
    // state and queue the symbols; without it, leave the state as it was and only look for
    // the first table entry the walk would read before anything was loaded there.
    // Return that address, or -1 when every read lands on a loaded entry.
    function automatic int decode_word(input logic [15:0] word, input bit commit);
        logic [htwd_pkg::IDX_W-1:0] saved_pos, step_addr, next_pos, sym_addr;
        htwd_pkg::t_count           saved_left;
        bit                         saved_done;
        t_symbol_exp                sym_out;
        int                         hole;
        hole = -1;
        saved_pos = walk_pos;
        saved_left = left_cnt;
        saved_done = walk_done;
        for (int i = 0; i < 16; i++) begin
            if (walk_done || hole >= 0) break;
            // Addresses are 10 bits wide, so every sum wraps around the table by itself.
            step_addr = walk_pos + htwd_pkg::IDX_W'(word[15-i]);
            if (!tree_written[step_addr]) begin
                hole = int'(step_addr);
            end else begin
                next_pos = walk_pos + tree_mem[step_addr][htwd_pkg::IDX_W-1:0];
                sym_addr = next_pos + 1'b1;
                if (!tree_written[next_pos]) begin
                    hole = int'(next_pos);
                end else if (tree_mem[next_pos] != '0) begin
                    walk_pos = next_pos;
                end else if (!tree_written[sym_addr]) begin
                    hole = int'(sym_addr);
                end else begin
                    left_cnt = left_cnt - 1'b1;
                    walk_done = (left_cnt == '0);
                    sym_out.sym = tree_mem[sym_addr][htwd_pkg::SYM_W-1:0];
                    sym_out.is_last = walk_done;
                    if (commit) pending_symbols.push_back(sym_out);
                    walk_pos = '0;
                end
            end
        end
        if (!commit) begin
            walk_pos = saved_pos;
            left_cnt = saved_left;
            walk_done = saved_done;
        end
        return hole;
    endfunction

    // Random entry for filling the table: a quarter are zero so random walks meet leaves.
    function automatic logic [htwd_pkg::ENTRY_W-1:0] fill_value();
        if ($urandom_range(3) == 0) return '0;
        return htwd_pkg::ENTRY_W'($urandom());
    endfunction

    // Increment that takes a node at from_pos to to_pos, with a random number of
    // whole table turns on top so that large and negative values show up.
    function automatic logic [htwd_pkg::ENTRY_W-1:0] link_value(input int from_pos,
                                                                input int to_pos);
        int span;
        span = (to_pos - from_pos + TABLE_SIZE) % TABLE_SIZE;
        return htwd_pkg::ENTRY_W'(span + TABLE_SIZE * (int'($urandom_range(63)) - 32));
    endfunction

    function automatic htwd_pkg::t_count pick_count();
        case ($urandom_range(9))
            0: return '0;
            1: return 31'd1;
            2: return 31'h7FFF_FFFF;
            3: return htwd_pkg::CNT_W'($urandom());
            default: return htwd_pkg::CNT_W'($urandom_range(2, 40));
        endcase
    endfunction

    // Send one command transaction: optionally idle first, hold start until the block
    // takes it, then update the predictor. Leave start high; a later step lowers it.
    task automatic issue(input logic [htwd_pkg::CMD_W-1:0] cmd,
                         input logic [htwd_pkg::IDX_W-1:0] idx,
                         input logic [htwd_pkg::ENTRY_W-1:0] val, input logic [15:0] word);
        if (gaps_on && $urandom_range(3) == 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_code_word   <= word;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        if (!(cmd == CMD_NONE || (cmd == htwd_pkg::CMD_CODE && walk_done))) items_sent++;
        case (cmd)
            htwd_pkg::CMD_LOAD: begin
                tree_mem[idx] = val;
                tree_written[idx] = 1'b1;
                n_loads++;
            end
            htwd_pkg::CMD_START: begin
                walk_pos = '0;
                left_cnt = count_reg;
                walk_done = (count_reg == '0);
                n_starts++;
            end
            htwd_pkg::CMD_CODE: begin
                void'(decode_word(word, 1'b1));
                n_codes++;
            end
            default: ;
        endcase
    endtask

    task automatic load_entry(input int idx, input logic [htwd_pkg::ENTRY_W-1:0] val);
        issue(htwd_pkg::CMD_LOAD, htwd_pkg::IDX_W'(idx), val, 16'($urandom()));
    endtask

    task automatic start_stream();
        issue(htwd_pkg::CMD_START, htwd_pkg::IDX_W'($urandom()),
              htwd_pkg::ENTRY_W'($urandom()), 16'($urandom()));
    endtask

    // Load any entry that this word would read before it was ever written, one at a
    // time, until the whole walk stays on loaded entries; then send the word.
    task automatic send_code(input logic [15:0] word);
        int hole;
        hole = decode_word(word, 1'b0);
        while (hole >= 0) begin
            load_entry(hole, fill_value());
            fills++;
            hole = decode_word(word, 1'b0);
        end
        issue(htwd_pkg::CMD_CODE, htwd_pkg::IDX_W'($urandom()),
              htwd_pkg::ENTRY_W'($urandom()), word);
    endtask

    // Drop start and wait until every predicted symbol is out and the block is quiet.
    // A load or start leaves nothing to wait for, so hold off a full word time on top.
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_symbols.size() != 0 || o_busy !== 1'b0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_count(input htwd_pkg::t_count value);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        count_reg = value;
    endtask

    // Build a complete binary tree rooted at entry 0: the root plus up to max_inner inner nodes.
    // Each other node takes two neighboring entries at a random free place in the table; every
    // inner node gets both children, so any code word walks it without leaving the tree.
    task automatic build_tree(input int max_inner);
        bit taken [TABLE_SIZE];
        int open_edge [$];
        int open_base [$];
        int inner_left, pick, edge_addr, base, spot;
        foreach (taken[j]) taken[j] = 1'b0;
        taken[0] = 1'b1;
        taken[1] = 1'b1;
        open_edge = '{0, 1};
        open_base = '{0, 0};
        inner_left = max_inner;
        while (open_edge.size() != 0) begin
            pick = $urandom_range(open_edge.size() - 1);
            edge_addr = open_edge[pick];
            base = open_base[pick];
            open_edge.delete(pick);
            open_base.delete(pick);
            do spot = $urandom_range(TABLE_SIZE - 1);
            while (taken[spot] || taken[(spot + 1) % TABLE_SIZE]);
            taken[spot] = 1'b1;
            taken[(spot + 1) % TABLE_SIZE] = 1'b1;
            load_entry(edge_addr, link_value(base, spot));
            if (inner_left > 0 && $urandom_range(2) != 0) begin
                // Inner node: its two increments are loaded when these edges come up.
                inner_left--;
                open_edge.push_back(spot);
                open_base.push_back(spot);
                open_edge.push_back((spot + 1) % TABLE_SIZE);
                open_base.push_back(spot);
            end else begin
                load_entry(spot, '0);
                load_entry((spot + 1) % TABLE_SIZE, htwd_pkg::ENTRY_W'($urandom()));
            end
        end
        trees_built++;
    endtask

    // Code words before any start, the unused command, and a start with a zero count
    // must all pass without a symbol.
    task automatic test_ignored_commands();
        issue(htwd_pkg::CMD_CODE, '0, '0, 16'hFFFF);
        issue(CMD_NONE, 10'h3FF, 16'hFFFF, 16'hFFFF);
        set_count('0);
        start_stream();
        send_code(16'h0000);
    endtask

    // Root bit 0 steps back by one to a leaf in the last entry; its symbol sits in entry 0
    // behind the wrap. Root bit 1 adds the most negative increment and lands on the root.
    // A count of five ends the stream inside the word; the rest and the next word drop.
    task automatic test_leaf_at_table_end();
        load_entry(0, 16'hFFFF);
        load_entry(1, 16'h8000);
        load_entry(1023, 16'h0000);
        set_count(31'd5);
        start_stream();
        send_code(16'h0000);
        send_code(16'h0000);
    endtask

    // Root links to an inner node in the last entry; that node's bit-1 increment wraps to
    // entry 0 and its largest positive value wraps the walk onto a leaf at 1022.
    // The bit-0 increment wraps forward to a leaf at entry 2 with symbol zero.
    task automatic test_wrapped_walk();
        load_entry(0, 16'h7FFF);
        load_entry(1, 16'hFFFF);
        load_entry(1023, 16'h0003);
        load_entry(1022, 16'h0000);
        load_entry(2, 16'h0000);
        load_entry(3, 16'h7F00);
        set_count(31'h7FFF_FFFF);
        start_stream();
        send_code(16'hFFFF);
        send_code(16'h0000);
        send_code(16'hA5C3);
        set_count(31'd1);
        start_stream();
        send_code(16'h5555);
    endtask

    // Well-formed streams over random trees, at times rebuilt, with random counts. Mix in
    // the unused command and restarts. Each stream drains before the count changes.
    task automatic test_random_streams();
        while (items_sent < 330) begin
            gaps_on = ($urandom_range(3) != 0);
            if (trees_built == 0 || $urandom_range(2) == 0) build_tree($urandom_range(1, 10));
            set_count(pick_count());
            start_stream();
            repeat ($urandom_range(2, 10)) begin
                case ($urandom_range(15))
                    0: issue(CMD_NONE, htwd_pkg::IDX_W'($urandom()),
                             htwd_pkg::ENTRY_W'($urandom()), 16'($urandom()));
                    1: start_stream();
                    default: send_code(16'($urandom()));
                endcase
            end
        end
    endtask

    // Overwrite random entries with random values so the walk roams the whole table.
    task automatic test_table_noise();
        gaps_on = 1'b1;
        repeat (70) begin
            case ($urandom_range(7))
                0, 1: load_entry($urandom_range(TABLE_SIZE - 1), fill_value());
                2: issue(CMD_NONE, htwd_pkg::IDX_W'($urandom()),
                         htwd_pkg::ENTRY_W'($urandom()), 16'($urandom()));
                3: begin
                    if ($urandom_range(2) == 0) set_count(pick_count());
                    start_stream();
                end
                default: send_code(16'($urandom()));
            endcase
        end
    endtask

    // Closing stretch without idles: one long stream, code words back to back.
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        build_tree($urandom_range(3, 8));
        set_count(31'h7FFF_FFFF);
        start_stream();
        while (items_sent < ITEM_TARGET) send_code(16'($urandom()));
    endtask

    // Compare each symbol strobe with the oldest prediction, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_symbol_valid === 1'b1) begin
            if (pending_symbols.size() == 0) begin
                report_mismatch($sformatf("symbol %02h with none predicted", o_symbol));
            end else begin
                want = pending_symbols.pop_front();
                symbols_checked++;
                if (o_symbol !== want.sym)
                    report_mismatch($sformatf("symbol #%0d: got %02h, want %02h",
                                              symbols_checked, o_symbol, want.sym));
                if (o_last_symbol !== want.is_last)
                    report_mismatch($sformatf("symbol #%0d: last flag %b, want %b",
                                              symbols_checked, o_last_symbol, want.is_last));
            end
        end
    end

    // Watchdog: count cycles in which no transaction, expected symbol or register write
    // happens; a strobe with nothing predicted is no progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && o_busy === 1'b0) || i_cfg_wr_en ||
            (o_symbol_valid === 1'b1 && pending_symbols.size() != 0))
        begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_ignored_commands();
        test_leaf_at_table_end();
        test_wrapped_walk();
        test_random_streams();
        test_table_noise();
        test_back_to_back();

        // Let the last word finish, then allow for a trailing stray symbol.
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("testbench: %0d commands taken (%0d loads, %0d starts, %0d code words)",
                 n_loads + n_starts + n_codes, n_loads, n_starts, n_codes);
        $display("testbench: %0d symbols checked, %0d trees built, %0d entries filled on demand",
                 symbols_checked, trees_built, fills);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
